// ===== src/srds_pkg.sv =====
// srds_pkg: shared types, codes and constants of the register-dictionary slave
// used by srds_ctrl, srds_dp and serial_register_dictionary_slave_unit
// no dependencies
`default_nettype none

package srds_pkg;

    // defaults of the top-level parameters
    localparam int DICT_DEPTH_DEF    = 32;
    localparam int RX_KEEP_DEF       = 8;
    localparam int PDO_MAX_WORDS_DEF = 6;

    // fixed field widths
    localparam int MODE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int START_W  = 5;
    localparam int COUNT_W  = 3;
    localparam int FLAGS_W  = 32;
    localparam int S_DATA_W = BYTE_W + START_W + COUNT_W;
    localparam int M_DATA_W = BYTE_W + FLAGS_W;
    localparam int FRAME_LEN = 5;
    localparam int INDEX_SPAN = 32;

    // input item kinds
    localparam logic [MODE_W-1:0] MODE_RX    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EOF   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLAGS = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PDO   = 2'd3;

    // result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_FLAGS = 1'b1;

    // protocol bytes
    localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h5A;
    localparam logic [BYTE_W-1:0] NAK_BYTE   = 8'h81;
    localparam logic [BYTE_W-1:0] PDO_BYTE   = 8'hA5;
    localparam logic [BYTE_W-1:0] WRITE_BIT  = 8'h80;
    localparam logic [BYTE_W-1:0] ECHO_MASK  = 8'h7f;
    localparam logic [BYTE_W-1:0] INDEX_MASK = 8'h1f;

    // output byte sources
    localparam int SEL_W = 4;
    localparam logic [SEL_W-1:0] SEL_PDO   = 4'd0;
    localparam logic [SEL_W-1:0] SEL_SYNC  = 4'd1;
    localparam logic [SEL_W-1:0] SEL_NAK   = 4'd2;
    localparam logic [SEL_W-1:0] SEL_ECHO  = 4'd3;
    localparam logic [SEL_W-1:0] SEL_ADDR  = 4'd4;
    localparam logic [SEL_W-1:0] SEL_HDR   = 4'd5;
    localparam logic [SEL_W-1:0] SEL_LO    = 4'd6;
    localparam logic [SEL_W-1:0] SEL_HI    = 4'd7;
    localparam logic [SEL_W-1:0] SEL_SUM   = 4'd8;
    localparam logic [SEL_W-1:0] SEL_FLAGS = 4'd9;

    typedef struct packed {
        logic             rx_store;
        logic             eof_clear;
        logic             dict_write;
        logic             rd_load;
        logic             pdo_load;
        logic             fetch;
        logic             clr_marks;
        logic             emit;
        logic [SEL_W-1:0] sel;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic frame_ok;
        logic chk_ok;
        logic is_write;
        logic left_zero;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== src/srds_ctrl.sv =====
// srds_ctrl: sequencer of the register-dictionary slave
// depends on srds_pkg; drives srds_dp through cmd_t, watches status_t
`default_nettype none

module srds_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic [srds_pkg::MODE_W-1:0]  mode,
    input  srds_pkg::status_t            status,
    output logic                         s_tready,
    output srds_pkg::cmd_t               cmd
);
    import srds_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] ST_NAK   = 4'd1;
    localparam logic [ST_W-1:0] ST_ECHO  = 4'd2;
    localparam logic [ST_W-1:0] ST_FLAGS = 4'd3;
    localparam logic [ST_W-1:0] ST_RSYNC = 4'd4;
    localparam logic [ST_W-1:0] ST_RADDR = 4'd5;
    localparam logic [ST_W-1:0] ST_PSYNC = 4'd6;
    localparam logic [ST_W-1:0] ST_PHDR  = 4'd7;
    localparam logic [ST_W-1:0] ST_FETCH = 4'd8;
    localparam logic [ST_W-1:0] ST_LO    = 4'd9;
    localparam logic [ST_W-1:0] ST_HI    = 4'd10;
    localparam logic [ST_W-1:0] ST_SUM   = 4'd11;

    logic [ST_W-1:0] state_reg;
    logic [ST_W-1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (mode)
                        MODE_RX:
                        begin
                            cmd.rx_store = 1'b1;
                        end
                        MODE_EOF:
                        begin
                            cmd.eof_clear = 1'b1;
                            if (status.frame_ok)
                            begin
                                if (!status.chk_ok)
                                begin
                                    state_next = ST_NAK;
                                end
                                else if (status.is_write)
                                begin
                                    cmd.dict_write = 1'b1;
                                    state_next     = ST_ECHO;
                                end
                                else
                                begin
                                    cmd.rd_load = 1'b1;
                                    state_next  = ST_RSYNC;
                                end
                            end
                        end
                        MODE_FLAGS:
                        begin
                            state_next = ST_FLAGS;
                        end
                        default:
                        begin
                            cmd.pdo_load = 1'b1;
                            state_next   = ST_PSYNC;
                        end
                    endcase
                end
            end
            ST_NAK:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_NAK;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ECHO:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_ECHO;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FLAGS:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.sel       = SEL_FLAGS;
                    cmd.last      = 1'b1;
                    cmd.clr_marks = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_RSYNC:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_SYNC;
                    state_next = ST_RADDR;
                end
            end
            ST_RADDR:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_ADDR;
                    state_next = ST_FETCH;
                end
            end
            ST_PSYNC:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_PDO;
                    state_next = ST_PHDR;
                end
            end
            ST_PHDR:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_HDR;
                    state_next = status.left_zero ? ST_SUM : ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_LO;
            end
            ST_LO:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_LO;
                    state_next = ST_HI;
                end
            end
            ST_HI:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_HI;
                    state_next = status.left_zero ? ST_SUM : ST_FETCH;
                end
            end
            ST_SUM:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_SUM;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/srds_dp.sv =====
// srds_dp: frame buffer, dictionary memory, edit marks, checksum and output register
// depends on srds_pkg; steered by srds_ctrl
`default_nettype none

module srds_dp #(
    parameter int DICT_DEPTH    = srds_pkg::DICT_DEPTH_DEF,
    parameter int RX_KEEP       = srds_pkg::RX_KEEP_DEF,
    parameter int PDO_MAX_WORDS = srds_pkg::PDO_MAX_WORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [srds_pkg::S_DATA_W-1:0] s_tdata,
    input  srds_pkg::cmd_t                cmd,
    output srds_pkg::status_t             status,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [srds_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser
);
    import srds_pkg::*;

    localparam int SLOT_W = $clog2(DICT_DEPTH);
    localparam int CNT_W  = $clog2(RX_KEEP + 1);
    localparam logic [COUNT_W-1:0] PDO_MAX = COUNT_W'(PDO_MAX_WORDS);
    localparam logic [CNT_W-1:0]   KEEP_CNT = CNT_W'(RX_KEEP);
    localparam logic [CNT_W-1:0]   FRAME_CNT = CNT_W'(FRAME_LEN);

    logic [BYTE_W-1:0]  rx_byte;
    logic [START_W-1:0] pdo_start;
    logic [COUNT_W-1:0] pdo_count;
    assign rx_byte   = s_tdata[BYTE_W-1:0];
    assign pdo_start = s_tdata[BYTE_W +: START_W];
    assign pdo_count = s_tdata[BYTE_W+START_W +: COUNT_W];

    // index to dictionary slot, wrapped by the depth
    logic [SLOT_W-1:0] slot_lut [INDEX_SPAN];
    for (genvar g = 0; g < INDEX_SPAN; g++)
    begin : g_lut
        assign slot_lut[g] = SLOT_W'(g % DICT_DEPTH);
    end

    logic [BYTE_W-1:0]     fb_reg [FRAME_LEN];
    logic [CNT_W-1:0]      count_reg;
    logic [START_W-1:0]    ptr_reg;
    logic [COUNT_W-1:0]    left_reg;
    logic [BYTE_W-1:0]     sum_reg;
    logic [BYTE_W-1:0]     hdr_reg;
    logic [DICT_DEPTH-1:0] marks_reg;
    logic [DICT_DEPTH-1:0] entry_valid_reg;
    logic                  q_valid_reg;
    logic [2*BYTE_W-1:0]   mem [DICT_DEPTH];
    logic [2*BYTE_W-1:0]   rd_word_reg;
    logic                  out_valid_reg;
    logic                  out_kind_reg;
    logic                  out_last_reg;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic [FLAGS_W-1:0]    out_flags_reg;

    logic [SLOT_W-1:0]     wr_slot;
    logic [SLOT_W-1:0]     rd_slot;
    logic [2*BYTE_W-1:0]   word;
    logic [BYTE_W-1:0]     lo;
    logic [BYTE_W-1:0]     hi;
    logic [COUNT_W-1:0]    pdo_n;
    logic [BYTE_W-1:0]     hdr_next;
    logic [BYTE_W-1:0]     emit_byte;
    logic                  out_free;

    assign wr_slot  = slot_lut[fb_reg[1][START_W-1:0]];
    assign rd_slot  = slot_lut[ptr_reg];
    assign word     = q_valid_reg ? rd_word_reg : '0;
    assign lo       = word[BYTE_W-1:0];
    assign hi       = word[2*BYTE_W-1:BYTE_W];
    assign pdo_n    = (pdo_count > PDO_MAX) ? PDO_MAX : pdo_count;
    assign hdr_next = {pdo_n, pdo_start};
    assign out_free = !out_valid_reg || m_tready;

    assign status.frame_ok  = (count_reg == FRAME_CNT) && (fb_reg[0] == SYNC_BYTE);
    assign status.chk_ok    = ((fb_reg[1] ^ fb_reg[2] ^ fb_reg[3]) == fb_reg[4]);
    assign status.is_write  = ((fb_reg[1] & WRITE_BIT) != '0);
    assign status.left_zero = (left_reg == '0);
    assign status.out_free  = out_free;

    always_comb
    begin
        case (cmd.sel)
            SEL_PDO:   emit_byte = PDO_BYTE;
            SEL_SYNC:  emit_byte = SYNC_BYTE;
            SEL_NAK:   emit_byte = NAK_BYTE;
            SEL_ECHO:  emit_byte = fb_reg[1] & ECHO_MASK;
            SEL_ADDR:  emit_byte = fb_reg[1];
            SEL_HDR:   emit_byte = hdr_reg;
            SEL_LO:    emit_byte = lo;
            SEL_HI:    emit_byte = hi;
            SEL_SUM:   emit_byte = sum_reg;
            default:   emit_byte = '0;
        endcase
    end

    // frame buffer bytes carry no reset
    always_ff @(posedge clk)
    begin
        if (cmd.rx_store)
        begin
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                if (count_reg == CNT_W'(i))
                begin
                    fb_reg[i] <= rx_byte;
                end
            end
        end
    end

    // dictionary storage
    always_ff @(posedge clk)
    begin
        if (cmd.dict_write)
        begin
            mem[wr_slot] <= {fb_reg[3], fb_reg[2]};
        end
        if (cmd.fetch)
        begin
            rd_word_reg <= mem[rd_slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            entry_valid_reg <= '0;
            marks_reg       <= '0;
            q_valid_reg     <= 1'b0;
            left_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.eof_clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.rx_store && (count_reg < KEEP_CNT))
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (cmd.dict_write)
            begin
                entry_valid_reg[wr_slot] <= 1'b1;
                marks_reg[wr_slot]       <= 1'b1;
            end
            else if (cmd.clr_marks)
            begin
                marks_reg <= '0;
            end

            if (cmd.fetch)
            begin
                q_valid_reg <= entry_valid_reg[rd_slot];
                left_reg    <= left_reg - 1'b1;
            end
            else if (cmd.rd_load)
            begin
                left_reg <= COUNT_W'(1);
            end
            else if (cmd.pdo_load)
            begin
                left_reg <= pdo_n;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.rd_load)
        begin
            ptr_reg <= fb_reg[1][START_W-1:0];
            sum_reg <= fb_reg[1];
        end
        else if (cmd.pdo_load)
        begin
            ptr_reg <= pdo_start;
            sum_reg <= hdr_next;
            hdr_reg <= hdr_next;
        end
        else
        begin
            if (cmd.fetch)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.emit && ((cmd.sel == SEL_LO) || (cmd.sel == SEL_HI)))
            begin
                sum_reg <= sum_reg ^ emit_byte;
            end
        end

        if (cmd.emit)
        begin
            out_kind_reg  <= (cmd.sel == SEL_FLAGS) ? KIND_FLAGS : KIND_BYTE;
            out_last_reg  <= cmd.last;
            out_byte_reg  <= emit_byte;
            out_flags_reg <= (cmd.sel == SEL_FLAGS) ? FLAGS_W'(marks_reg) : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_flags_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;

endmodule

`default_nettype wire

// ===== src/serial_register_dictionary_slave_unit.sv =====
// serial_register_dictionary_slave_unit: top level of the register-dictionary slave
// depends on srds_pkg, srds_ctrl (sequencer) and srds_dp (datapath)
`default_nettype none

// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+---------------------------------------------
// s_ (in)   | sink      | s_tvalid/s_tready  | tuser: mode; tdata: rx_byte, pdo_start,
//           |           |                    |   pdo_count
// m_ (out)  | source    | m_tvalid/m_tready  | tuser: out_kind; tlast: last;
//           |           |                    |   tdata: tx_byte, edit_flags
//
// a received byte or an idle with no answer leaves the sequencer in idle
// an answer then sends its output bytes one at a time, with one memory read per word:
// nak or echo 1 byte, flags 1 word, read 5 bytes, pdo 3 + 2*n bytes (n <= PDO_MAX_WORDS)
// input is held off while an answer is sent; a stalled output holds the sequencer
// at its next byte, and the last result may still wait when the next item is taken
// async reset clears control state and the per-entry valid bits, so every entry reads zero

module serial_register_dictionary_slave_unit #(
    parameter int DICT_DEPTH    = srds_pkg::DICT_DEPTH_DEF,
    parameter int RX_KEEP       = srds_pkg::RX_KEEP_DEF,
    parameter int PDO_MAX_WORDS = srds_pkg::PDO_MAX_WORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [srds_pkg::S_DATA_W-1:0] s_tdata,  // rx_byte, pdo_start, pdo_count
    input  logic [srds_pkg::MODE_W-1:0]   s_tuser,  // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [srds_pkg::M_DATA_W-1:0] m_tdata,  // tx_byte, edit_flags
    output logic                          m_tlast,
    output logic                          m_tuser   // out_kind
);
    import srds_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: walks each answer one output byte at a time
    srds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .mode     (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // datapath: frame buffer, dictionary, marks, checksum, output register
    srds_dp #(
        .DICT_DEPTH    (DICT_DEPTH),
        .RX_KEEP       (RX_KEEP),
        .PDO_MAX_WORDS (PDO_MAX_WORDS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // returning to idle only ever happens right after loading a final result
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_tready) |-> (m_tvalid && m_tlast))
        else $error("input reopened without a final result");

    // a flag word carries no transmit byte
    a_flags_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_FLAGS)) |-> (m_tdata[BYTE_W-1:0] == '0))
        else $error("flag result with nonzero byte");

    // a transmit byte carries no flag word
    a_byte_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_BYTE)) |-> (m_tdata[M_DATA_W-1:BYTE_W] == '0))
        else $error("byte result with nonzero flags");

endmodule

`default_nettype wire

// ===== verif/tb_serial_register_dictionary_slave_unit.sv =====
`timescale 1ns / 100ps
// tb_serial_register_dictionary_slave_unit: self-checking bench for the register-dictionary slave
// sends framed link bytes, flag fetches and pdo requests and checks each result item
// depends on srds_pkg and serial_register_dictionary_slave_unit

module tb_serial_register_dictionary_slave_unit;

    import srds_pkg::*;

    localparam int DICT_SIZE    = DICT_DEPTH_DEF;
    localparam int KEEP_LIMIT   = RX_KEEP_DEF;
    localparam int PDO_WORDS    = PDO_MAX_WORDS_DEF;
    localparam int STIM_ITEMS   = 480;
    localparam int QUIET_LIMIT  = 1000;   // cycles with no handshake on either side
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 40;

    // one input item as the link side sees it
    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [BYTE_W-1:0]  rx_byte;
        logic [START_W-1:0] pdo_start;
        logic [COUNT_W-1:0] pdo_count;
    } link_item_t;

    // one result item
    typedef struct {
        logic               kind;
        logic [BYTE_W-1:0]  tx_byte;
        logic               last;
        logic [FLAGS_W-1:0] flags;
    } answer_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // rx_byte, pdo_start, pdo_count
    logic [MODE_W-1:0]   s_tuser  = MODE_RX;   // mode
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;   // tx_byte, edit_flags
    logic                m_tlast;
    logic                m_tuser;   // out_kind

    link_item_t pending_items[$];
    answer_t    expected_answers[$];

    // mirror of the slave state
    logic [BYTE_W-1:0]  rx_frame [FRAME_LEN];
    int                 rx_len;
    logic [15:0]        dict_mirror [DICT_SIZE] = '{default: '0};
    logic [FLAGS_W-1:0] edit_mirror = '0;

    int fail_count;
    int items_taken;
    int answers_checked;
    int writes_seen;
    int reads_seen;
    int naks_seen;
    int pdos_seen;
    int fetches_seen;
    int quiet_cycles;

    // sender and receiver pacing
    bit          item_taken;
    int          burst_left;
    int          gap_left;
    bit          steady;
    logic [15:0] ready_mask = 16'hffff;
    int          ready_tick;

    serial_register_dictionary_slave_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // dictionary entry addressed by an index byte or a pdo position
    function automatic logic [4:0] dict_index(input int unsigned raw);
        return 5'((raw & INDEX_MASK) % DICT_SIZE);
    endfunction

    function automatic void push_answer(input logic kind, input logic [BYTE_W-1:0] tx,
                                        input logic last, input logic [FLAGS_W-1:0] flags);
        answer_t a;
        a.kind    = kind;
        a.tx_byte = tx;
        a.last    = last;
        a.flags   = flags;
        expected_answers.push_back(a);
    endfunction

    // expected results of one accepted item, updating the mirrored state
    function automatic void predict_answer(input link_item_t it);
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] hdr;
        logic [BYTE_W-1:0] sum;
        logic [15:0]       word;
        int                got;
        int                words;
        int                i;
        case (it.mode)
            MODE_RX:
            begin
                // only the first five bytes are kept, the count runs on to the keep limit
                if (rx_len < FRAME_LEN)
                    rx_frame[rx_len] = it.rx_byte;
                if (rx_len < KEEP_LIMIT)
                    rx_len++;
            end
            MODE_EOF:
            begin
                got    = rx_len;
                rx_len = 0;
                if (got == FRAME_LEN && rx_frame[0] == SYNC_BYTE)
                begin
                    addr = rx_frame[1];
                    if ((rx_frame[1] ^ rx_frame[2] ^ rx_frame[3]) != rx_frame[4])
                    begin
                        push_answer(KIND_BYTE, NAK_BYTE, 1'b1, '0);
                        naks_seen++;
                    end
                    else if ((addr & WRITE_BIT) != '0)
                    begin
                        // little-endian word, echo drops the write bit
                        dict_mirror[dict_index(addr)] = {rx_frame[3], rx_frame[2]};
                        edit_mirror[dict_index(addr)] = 1'b1;
                        push_answer(KIND_BYTE, addr & ECHO_MASK, 1'b1, '0);
                        writes_seen++;
                    end
                    else
                    begin
                        word = dict_mirror[dict_index(addr)];
                        lo   = word[7:0];
                        hi   = word[15:8];
                        push_answer(KIND_BYTE, SYNC_BYTE, 1'b0, '0);
                        push_answer(KIND_BYTE, addr, 1'b0, '0);
                        push_answer(KIND_BYTE, lo, 1'b0, '0);
                        push_answer(KIND_BYTE, hi, 1'b0, '0);
                        push_answer(KIND_BYTE, addr ^ lo ^ hi, 1'b1, '0);
                        reads_seen++;
                    end
                end
            end
            MODE_FLAGS:
            begin
                push_answer(KIND_FLAGS, '0, 1'b1, edit_mirror);
                edit_mirror = '0;
                fetches_seen++;
            end
            default:
            begin
                // pdo: count saturates, index wraps around the dictionary
                words = (it.pdo_count > PDO_WORDS) ? PDO_WORDS : int'(it.pdo_count);
                hdr   = 8'((words << 5) | it.pdo_start);
                sum   = hdr;
                push_answer(KIND_BYTE, PDO_BYTE, 1'b0, '0);
                push_answer(KIND_BYTE, hdr, 1'b0, '0);
                for (i = 0; i < words; i++)
                begin
                    word = dict_mirror[dict_index(it.pdo_start + i)];
                    sum  = sum ^ word[7:0] ^ word[15:8];
                    push_answer(KIND_BYTE, word[7:0], 1'b0, '0);
                    push_answer(KIND_BYTE, word[15:8], 1'b0, '0);
                end
                push_answer(KIND_BYTE, sum, 1'b1, '0);
                pdos_seen++;
            end
        endcase
    endfunction

    // unused fields get random values so every input bit toggles
    function automatic void queue_item(input logic [MODE_W-1:0] mode,
                                       input logic [BYTE_W-1:0] rx);
        link_item_t it;
        it.mode      = mode;
        it.rx_byte   = rx;
        it.pdo_start = START_W'($urandom);
        it.pdo_count = COUNT_W'($urandom);
        pending_items.push_back(it);
    endfunction

    function automatic void queue_pdo(input logic [START_W-1:0] start,
                                      input logic [COUNT_W-1:0] count);
        link_item_t it;
        it.mode      = MODE_PDO;
        it.rx_byte   = BYTE_W'($urandom);
        it.pdo_start = start;
        it.pdo_count = count;
        pending_items.push_back(it);
    endfunction

    // five link bytes followed by line idle
    function automatic void queue_frame(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] addr,
                                        input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi,
                                        input logic [BYTE_W-1:0] chk);
        queue_item(MODE_RX, b0);
        queue_item(MODE_RX, addr);
        queue_item(MODE_RX, lo);
        queue_item(MODE_RX, hi);
        queue_item(MODE_RX, chk);
        queue_item(MODE_EOF, BYTE_W'($urandom));
    endfunction

    // input tap: every accepted item goes through the predictor
    always @(posedge clk)
    begin
        link_item_t it;
        if (rst_n && s_tvalid && s_tready)
        begin
            it.mode      = s_tuser;
            it.rx_byte   = s_tdata[BYTE_W-1:0];
            it.pdo_start = s_tdata[BYTE_W +: START_W];
            it.pdo_count = s_tdata[BYTE_W+START_W +: COUNT_W];
            predict_answer(it);
            items_taken++;
            item_taken = 1'b1;
        end
    end

    // driver: bursts of items with random gaps, now and then a stretch with no gaps
    always @(negedge clk)
    begin
        bit took;
        took       = item_taken;
        item_taken = 1'b0;
        if (rst_n)
        begin
            if (took)
            begin
                void'(pending_items.pop_front());
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 7) == 0)
                        steady = ~steady;
                    gap_left = steady ? 0 : $urandom_range(0, 24);
                end
            end
            // an offered item stays on the bus until it is taken
            if (!s_tvalid || took)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 16);
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_items[0].mode;
                    s_tdata  <= {pending_items[0].pdo_count, pending_items[0].pdo_start,
                                 pending_items[0].rx_byte};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: ready follows a rotating 16-bit mask, with a new random mask drawn periodically
    always @(negedge clk)
    begin
        ready_tick++;
        if (ready_tick % 64 == 0)
        begin
            case ($urandom_range(0, 3))
                0:       ready_mask = 16'hffff;
                1:       ready_mask = 16'($urandom) | 16'h0001;
                2:       ready_mask = 16'($urandom & $urandom) | 16'h0001;
                default: ready_mask = 16'($urandom | $urandom) | 16'h8000;
            endcase
        end
        m_tready <= ready_mask[ready_tick % 16];
    end

    // monitor: each result against the oldest expectation
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_answers.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing expected: kind %0d byte %02h",
                                          m_tuser, m_tdata[BYTE_W-1:0]));
            end
            else
            begin
                want = expected_answers.pop_front();
                answers_checked++;
                if (m_tuser !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", m_tuser, want.kind));
                if (m_tdata[BYTE_W-1:0] !== want.tx_byte)
                    report_mismatch($sformatf("tx byte %02h, expected %02h",
                                              m_tdata[BYTE_W-1:0], want.tx_byte));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %0d, expected %0d", m_tlast, want.last));
                if (m_tdata[BYTE_W +: FLAGS_W] !== want.flags)
                    report_mismatch($sformatf("edit flags %08h, expected %08h",
                                              m_tdata[BYTE_W +: FLAGS_W], want.flags));
            end
        end
    end

    // watchdog on cycles with no handshake at all
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] b0;
        int                pick;
        int                len;
        int                i;

        // directed: top entry written with all ones and read back through an index
        // with the upper address bits set, flag fetch twice, pdo with wrap and
        // saturation, empty pdo, check mismatch on a write, idle on an empty buffer
        queue_frame(SYNC_BYTE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_frame(SYNC_BYTE, 8'h7F, 8'h00, 8'h00, 8'h7F);
        queue_item(MODE_FLAGS, 8'h00);
        queue_item(MODE_FLAGS, 8'hFF);
        queue_pdo(5'd31, 3'd7);
        queue_pdo(5'd0, 3'd0);
        queue_frame(SYNC_BYTE, 8'h80, 8'h12, 8'h34, 8'hA7);
        queue_item(MODE_EOF, 8'h00);

        // random: mostly well-formed frames, the rest pdo, fetches and broken traffic
        while (pending_items.size() < STIM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            addr = BYTE_W'($urandom);
            lo   = BYTE_W'($urandom);
            hi   = BYTE_W'($urandom);
            if (pick < 34)
            begin
                addr = addr | WRITE_BIT;
                queue_frame(SYNC_BYTE, addr, lo, hi, addr ^ lo ^ hi);
            end
            else if (pick < 56)
            begin
                addr = addr & ECHO_MASK;
                queue_frame(SYNC_BYTE, addr, lo, hi, addr ^ lo ^ hi);
            end
            else if (pick < 66)
                queue_pdo(START_W'($urandom), COUNT_W'($urandom));
            else if (pick < 72)
                queue_item(MODE_FLAGS, BYTE_W'($urandom));
            else if (pick < 78)
                // one bit of the check byte flipped
                queue_frame(SYNC_BYTE, addr, lo, hi,
                            addr ^ lo ^ hi ^ (8'h01 << $urandom_range(0, 7)));
            else if (pick < 83)
            begin
                b0 = BYTE_W'($urandom);
                if (b0 == SYNC_BYTE)
                    b0 = ~b0;
                queue_frame(b0, addr, lo, hi, addr ^ lo ^ hi);
            end
            else if (pick < 92)
            begin
                // runt or overlong frame, up to past the keep limit
                len = $urandom_range(0, KEEP_LIMIT + 3);
                if (len == FRAME_LEN)
                    len++;
                for (i = 0; i < len; i++)
                    queue_item(MODE_RX, (i == 0) ? SYNC_BYTE : BYTE_W'($urandom));
                queue_item(MODE_EOF, BYTE_W'($urandom));
            end
            else
                queue_item(MODE_W'($urandom), BYTE_W'($urandom));
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_answers.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_answers.size()));

        $display("covered %0d items: %0d writes, %0d reads, %0d check errors, %0d pdo, %0d fetches",
                 items_taken, writes_seen, reads_seen, naks_seen, pdos_seen, fetches_seen);
        $display("%0d results checked, %0d mismatches", answers_checked, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
